// ----- hdl/brba_pkg.sv -----
`timescale 1ns / 1ps

package brba_pkg;

  // Table geometry and address format
  localparam int REGION_SLOTS = 64;
  localparam int PAGE_BYTES   = 4096;
  localparam int PAGE_LOG2    = $clog2(PAGE_BYTES);
  localparam int ADDR_W       = 32;
  localparam int ALIGN_W      = 5;
  localparam int TOP_W        = 21;
  localparam int CFG_IDX_W    = 1;

  localparam logic [ADDR_W-1:0] PAGE_MASK    = ADDR_W'(PAGE_BYTES - 1);
  localparam logic [TOP_W-1:0]  TOP_PAGE_MAX = {TOP_W{1'b1}};

  // Action codes
  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_START = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END   = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NO_SLOT = 2'd1,
    STATUS_NO_FIT  = 2'd2
  } status_t;

  // Request word that walks the row of slot cells.
  // For an add, piece a is always the next piece to place; piece b waits behind it.
  typedef struct packed {
    logic              vld;
    logic              alloc;
    logic [1:0]        pend;
    logic [ADDR_W-1:0] a_start;
    logic [ADDR_W-1:0] a_end;
    logic [ADDR_W-1:0] b_start;
    logic [ADDR_W-1:0] b_end;
    logic [ADDR_W-1:0] len;
    logic [ALIGN_W-1:0] lg;
    logic              granted;
    logic [ADDR_W-1:0] addr;
  } pkt_t;

endpackage

// ----- hdl/brba_cell.sv -----
`timescale 1ns / 1ps

module brba_cell import brba_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  pkt_t pkt_i,
  output pkt_t pkt_o
);

  logic [ADDR_W-1:0] start_r, start_nxt;
  logic [ADDR_W-1:0] end_r, end_nxt;
  pkt_t              pkt_r, pkt_nxt;

  logic [ADDR_W-1:0] amask;
  logic [ADDR_W:0]   first;
  logic [ADDR_W-1:0] last;
  logic [ADDR_W-1:0] span;
  logic              fit;

  // Aligned window of this slot for an allocation
  always_comb begin
    amask = ~({ADDR_W{1'b1}} << pkt_i.lg);
    first = ({1'b0, start_r} + {1'b0, amask}) & {1'b1, ~amask};
    last  = end_r & ~amask;
    span  = last - first[ADDR_W-1:0];
    fit   = (first < {1'b0, last}) && (span >= pkt_i.len);
  end

  // Serve the word if it is meant for this slot, then pass it on
  always_comb begin
    start_nxt = start_r;
    end_nxt   = end_r;
    pkt_nxt   = pkt_i;
    if (pkt_i.vld) begin
      if (pkt_i.alloc == ACT_ADD) begin
        if (start_r == '0 && pkt_i.pend[0]) begin
          start_nxt       = pkt_i.a_start;
          end_nxt         = pkt_i.a_end;
          pkt_nxt.a_start = pkt_i.b_start;
          pkt_nxt.a_end   = pkt_i.b_end;
          pkt_nxt.pend    = {1'b0, pkt_i.pend[1]};
        end
      end else if (!pkt_i.granted && fit) begin
        start_nxt       = first[ADDR_W-1:0] + pkt_i.len;
        pkt_nxt.addr    = first[ADDR_W-1:0];
        pkt_nxt.granted = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      end_r   <= '0;
      pkt_r   <= '0;
    end else begin
      start_r <= start_nxt;
      end_r   <= end_nxt;
      pkt_r   <= pkt_nxt;
    end
  end

  assign pkt_o = pkt_r;

endmodule

// ----- hdl/boot_region_bump_allocator_top.sv -----
`timescale 1ns / 1ps

// Region table with first-fit bump allocation.
// Input channel (in_*): one word per request. in_action selects an add of the
// region [in_region_start, in_region_end) or an allocation of in_alloc_length
// bytes at 2^in_align_log2 alignment. Every word yields exactly one result
// word on the out_* channel: status, granted address and highest page seen.
// Configuration (cfg_*): kernel image start and end, written while idle.
// The 64 slots live in a row of cells; a request word walks the row one cell
// per clock. The word is registered at the accepting edge and then passes the
// decode stage, 64 cells, hold stage and output register, raising out_valid.
// One word is in flight at a time: in_stall stays high from acceptance until
// its result is loaded into the output register, so a new word is accepted
// only once the result of the last one has been loaded there.
// A stalled result holds in the output register; the next request may already
// be accepted and walk the row while it waits.
// Reset (rst_n low, synchronous) empties every slot, clears the highest page,
// and loads the kernel range with 1 MiB to 2 MiB.
module boot_region_bump_allocator_top import brba_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_action,
  input  logic [ADDR_W-1:0]    in_region_start,
  input  logic [ADDR_W-1:0]    in_region_end,
  input  logic [ADDR_W-1:0]    in_alloc_length,
  input  logic [ALIGN_W-1:0]   in_align_log2,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic [ADDR_W-1:0]    out_alloc_addr,
  output logic [TOP_W-1:0]     out_max_page,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata
);

  logic [ADDR_W-1:0] kstart_r, kend_r;
  logic              busy_r, busy_nxt;

  logic              stg_vld_r;
  logic              act_r;
  logic [ADDR_W-1:0] rs_r, re_r, len_r;
  logic [ALIGN_W-1:0] lg_r;

  logic [TOP_W-1:0]  top_r, top_nxt;
  pkt_t              head_r, head_nxt;
  pkt_t              chain [0:REGION_SLOTS];

  logic              hold_vld_r;
  logic [1:0]        hold_status_r;
  logic [ADDR_W-1:0] hold_addr_r;
  logic [TOP_W-1:0]  hold_top_r;

  logic              out_vld_r;
  logic [1:0]        out_status_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [TOP_W-1:0]  out_top_r;

  logic              in_acc;
  logic              out_load;

  logic [ADDR_W:0]   s_up, s, ke, e33, ks33;
  logic [ADDR_W-1:0] e, ks;
  logic [ADDR_W-1:0] pn;
  logic [TOP_W-1:0]  pn_sat;
  logic              empty, kvalid, in_kernel, overlap, lo, hi;

  pkt_t              tail;
  status_t           res_status;

  assign in_acc   = in_valid && !busy_r;
  assign out_load = hold_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = busy_r;

  // Kernel range registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kstart_r <= ADDR_W'(1048576);
      kend_r   <= ADDR_W'(2097152);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KERNEL_START: kstart_r <= cfg_wdata;
        CFG_KERNEL_END:   kend_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Busy from acceptance until the result reaches the output register
  always_comb begin
    busy_nxt = busy_r;
    if (in_acc) begin
      busy_nxt = 1'b1;
    end else if (out_load) begin
      busy_nxt = 1'b0;
    end
  end

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      stg_vld_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      stg_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= in_action;
      rs_r  <= in_region_start;
      re_r  <= in_region_end;
      len_r <= in_alloc_length;
      lg_r  <= in_align_log2;
    end
  end

  // Page-align the region and the kernel range, classify against the kernel
  always_comb begin
    s_up   = ({1'b0, rs_r} + {1'b0, PAGE_MASK}) & {1'b1, ~PAGE_MASK};
    s      = (s_up == '0) ? (ADDR_W + 1)'(PAGE_BYTES) : s_up;
    e      = re_r & ~PAGE_MASK;
    e33    = {1'b0, e};
    ks     = kstart_r & ~PAGE_MASK;
    ks33   = {1'b0, ks};
    ke     = ({1'b0, kend_r} + {1'b0, PAGE_MASK}) & {1'b1, ~PAGE_MASK};
    empty  = s >= e33;
    pn     = e >> PAGE_LOG2;
    pn_sat = (pn > ADDR_W'(TOP_PAGE_MAX)) ? TOP_PAGE_MAX : pn[TOP_W-1:0];
    kvalid    = ke > ks33;
    in_kernel = (s >= ks33) && (e33 < ke);
    overlap   = ((s < ke) && (e33 >= ke)) || ((s <= ks33) && (e33 > ks33));
    lo        = s < ks33;
    hi        = e33 > ke;
  end

  // Build the word that enters the first cell
  always_comb begin
    head_nxt       = '0;
    head_nxt.vld   = stg_vld_r;
    head_nxt.alloc = act_r;
    head_nxt.len   = len_r;
    head_nxt.lg    = lg_r;
    if (act_r == ACT_ADD && !empty) begin
      if (kvalid && in_kernel) begin
        head_nxt.pend = 2'b00;
      end else if (kvalid && overlap) begin
        if (lo && hi) begin
          head_nxt.a_start = s[ADDR_W-1:0];
          head_nxt.a_end   = ks;
          head_nxt.b_start = ke[ADDR_W-1:0];
          head_nxt.b_end   = e;
          head_nxt.pend    = 2'b11;
        end else if (lo) begin
          head_nxt.a_start = s[ADDR_W-1:0];
          head_nxt.a_end   = ks;
          head_nxt.pend    = 2'b01;
        end else if (hi) begin
          head_nxt.a_start = ke[ADDR_W-1:0];
          head_nxt.a_end   = e;
          head_nxt.pend    = 2'b01;
        end
      end else begin
        head_nxt.a_start = s[ADDR_W-1:0];
        head_nxt.a_end   = e;
        head_nxt.pend    = 2'b01;
      end
    end
  end

  // Raise the highest page on a non-empty add
  always_comb begin
    top_nxt = top_r;
    if (stg_vld_r && act_r == ACT_ADD && !empty && pn_sat > top_r) begin
      top_nxt = pn_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r  <= '0;
      head_r <= '0;
    end else begin
      top_r  <= top_nxt;
      head_r <= head_nxt;
    end
  end

  // Row of slot cells
  assign chain[0] = head_r;

  for (genvar i = 0; i < REGION_SLOTS; i++) begin : g_cell
    brba_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .pkt_i (chain[i]),
      .pkt_o (chain[i+1])
    );
  end

  assign tail = chain[REGION_SLOTS];

  // Turn the word leaving the row into a result
  always_comb begin
    if (tail.alloc == ACT_ALLOC) begin
      res_status = tail.granted ? STATUS_OK : STATUS_NO_FIT;
    end else begin
      res_status = tail.pend[0] ? STATUS_NO_SLOT : STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else if (tail.vld) begin
      hold_vld_r <= 1'b1;
    end else if (out_load) begin
      hold_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tail.vld) begin
      hold_status_r <= res_status;
      hold_addr_r   <= (tail.alloc == ACT_ALLOC && tail.granted) ? tail.addr : '0;
      hold_top_r    <= top_r;
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= hold_status_r;
      out_addr_r   <= hold_addr_r;
      out_top_r    <= hold_top_r;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_status     = out_status_r;
  assign out_alloc_addr = out_addr_r;
  assign out_max_page   = out_top_r;

endmodule
